>>> hdl/pba_pkg.sv
// shared constants, codes and transaction types of the page bitmap allocator
package pba_pkg;

   localparam int MAP_PAGES   = 65536;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int WORD_BITS   = 64;
   localparam int WORD_IDX_W  = $clog2(WORD_BITS);
   localparam int MAP_WORDS   = MAP_PAGES / WORD_BITS;
   localparam int WADDR_W     = $clog2(MAP_WORDS);
   localparam int PIDX_W      = $clog2(MAP_PAGES);
   localparam int CNT_W       = PIDX_W + 1;
   localparam int RUN_W       = PIDX_W + 2;
   localparam int STEP_BITS   = 8;
   localparam int STEP_W      = $clog2(STEP_BITS);
   localparam int SUB_W       = $clog2(WORD_BITS / STEP_BITS);

   // request modes
   localparam logic [2:0] MODE_ALLOC_ONE     = 3'd0;
   localparam logic [2:0] MODE_ALLOC_RUN     = 3'd1;
   localparam logic [2:0] MODE_FREE          = 3'd2;
   localparam logic [2:0] MODE_RESERVE_ONE   = 3'd3;
   localparam logic [2:0] MODE_RESERVE_RANGE = 3'd4;
   localparam logic [2:0] MODE_RESERVE_SIZE  = 3'd5;

   // result status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] addr;
      logic [31:0] end_addr;
      logic [31:0] length;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [31:0]      base_addr;
      logic [CNT_W-1:0] used_pages;
   } rsp_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] bits;
      logic [RUN_W-1:0]     run;
      logic [RUN_W-1:0]     len;
   } run_in_type;

   typedef struct packed {
      logic              found;
      logic [STEP_W-1:0] pos;
      logic [RUN_W-1:0]  run;
   } run_out_type;

endpackage

>>> hdl/pba_ram.sv
// generic simple dual-port ram with registered read
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pba_run_step.sv
// free-run counter step over one byte of the used-page map
module pba_run_step (
   input  pba_pkg::run_in_type  step_in,
   output pba_pkg::run_out_type step_out
);

   // walk the bits low to high, restarting the run on a used page
   always_comb begin
      logic [pba_pkg::RUN_W-1:0]  run;
      logic                       found;
      logic [pba_pkg::STEP_W-1:0] pos;
      run   = step_in.run;
      found = 1'b0;
      pos   = '0;
      for (int k = 0; k < pba_pkg::STEP_BITS; k++) begin
         if (!found) begin
            if (step_in.bits[k]) begin
               run = '0;
            end else begin
               run = run + 1'b1;
               if (run == step_in.len) begin
                  found = 1'b1;
                  pos   = pba_pkg::STEP_W'(k);
               end
            end
         end
      end
      step_out.found = found;
      step_out.pos   = pos;
      step_out.run   = run;
   end

endmodule

>>> hdl/page_bitmap_allocator.sv
// page frame allocator over a used-page bitmap held in a word-wide ram
//
// Requests arrive on the req_ channel (valid/stall), one transaction per
// request, and each gives exactly one result transaction on the rsp_ channel.
// The map lives in a ram of 1024 words of 64 page marks; every step is a
// registered read of one word, and mark and free steps then modify and write it back.
// A free reads and rewrites one word; a reserve reads every map word spanned in
// a check pass and, if all are free, again in a mark pass; an alloc scans the
// map first-fit, byte by byte within words holding both used and free pages,
// then marks the run found.
// Only one request is worked on at a time; the next request is taken once the
// result has moved into the output register, so a stalled receiver holds the
// result there while a new request already runs.
// After reset the block sweeps the map clear, one word a cycle, over all 1024
// words, during which req_stall is high. rsp_valid is low after reset.
module page_bitmap_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pba_pkg::rsp_type rsp_data
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_SREAD  = 4'd3;
   localparam logic [3:0] ST_SWORD  = 4'd4;
   localparam logic [3:0] ST_SBITS  = 4'd5;
   localparam logic [3:0] ST_SFOUND = 4'd6;
   localparam logic [3:0] ST_RREAD  = 4'd7;
   localparam logic [3:0] ST_RWORD  = 4'd8;
   localparam logic [3:0] ST_FREAD  = 4'd9;
   localparam logic [3:0] ST_FWORD  = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   localparam logic [pba_pkg::WADDR_W-1:0] LAST_WORD =
      pba_pkg::WADDR_W'(pba_pkg::MAP_WORDS - 1);
   localparam logic [pba_pkg::SUB_W-1:0] LAST_SUB =
      pba_pkg::SUB_W'(pba_pkg::WORD_BITS / pba_pkg::STEP_BITS - 1);

   logic [3:0]                       state_ff, state_in;
   pba_pkg::req_type                 req_ff, req_in;
   logic [pba_pkg::WADDR_W-1:0]      waddr_ff, waddr_in;
   logic [pba_pkg::WORD_BITS-1:0]    word_ff, word_in;
   logic [pba_pkg::SUB_W-1:0]        sub_ff, sub_in;
   logic [pba_pkg::RUN_W-1:0]        run_ff, run_in;
   logic [pba_pkg::RUN_W-1:0]        len_ff, len_in;
   logic [pba_pkg::PIDX_W-1:0]       first_ff, first_in;
   logic [pba_pkg::PIDX_W-1:0]       last_ff, last_in;
   logic                             check_ff, check_in;
   logic [pba_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                             res_ok_ff, res_ok_in;
   logic [31:0]                      res_base_ff, res_base_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             wr_en;
   logic [pba_pkg::WADDR_W-1:0]      wr_addr;
   logic [pba_pkg::WORD_BITS-1:0]    wr_data;
   logic [pba_pkg::WORD_BITS-1:0]    rd_data;
   pba_pkg::run_in_type              step_in;
   pba_pkg::run_out_type             step_out;

   // used-page map
   pba_ram #(
      .WIDTH(pba_pkg::WORD_BITS),
      .DEPTH(pba_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (waddr_ff),
      .rd_data (rd_data)
   );

   // byte-wide run counter for mixed words
   pba_run_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   always_comb begin
      step_in.bits = word_ff[sub_ff * pba_pkg::STEP_BITS +: pba_pkg::STEP_BITS];
      step_in.run  = run_ff;
      step_in.len  = len_ff;
   end

   // sequencer
   always_comb begin
      logic [31:0]                   pidx_wide;
      logic [31:0]                   end_pg;
      logic [32:0]                   last_size;
      logic [31:0]                   size_pg;
      logic [pba_pkg::RUN_W-1:0]     sum;
      logic [pba_pkg::WORD_IDX_W-1:0] lo;
      logic [pba_pkg::WORD_IDX_W-1:0] hi;
      logic [pba_pkg::WORD_BITS-1:0] mask;
      logic                          is_last;
      logic                          fin;
      logic                          fin_ok;
      logic [pba_pkg::PIDX_W+pba_pkg::PAGE_SHIFT-1:0] base_wide;

      state_in     = state_ff;
      req_in       = req_ff;
      waddr_in     = waddr_ff;
      word_in      = word_ff;
      sub_in       = sub_ff;
      run_in       = run_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      check_in     = check_ff;
      count_in     = count_ff;
      res_ok_in    = res_ok_ff;
      res_base_in  = res_base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = waddr_ff;
      wr_data      = '0;
      fin          = 1'b0;
      fin_ok       = 1'b0;

      pidx_wide = req_ff.addr >> pba_pkg::PAGE_SHIFT;
      end_pg    = req_ff.end_addr >> pba_pkg::PAGE_SHIFT;
      last_size = {1'b0, req_ff.addr} + {1'b0, req_ff.length} - 33'd1;
      size_pg   = last_size[31:0] >> pba_pkg::PAGE_SHIFT;
      sum       = run_ff + pba_pkg::RUN_W'(pba_pkg::WORD_BITS);
      lo = (waddr_ff == first_ff[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W]) ?
           first_ff[pba_pkg::WORD_IDX_W-1:0] : '0;
      hi = (waddr_ff == last_ff[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W]) ?
           last_ff[pba_pkg::WORD_IDX_W-1:0] : pba_pkg::WORD_IDX_W'(pba_pkg::WORD_BITS - 1);
      mask = ({pba_pkg::WORD_BITS{1'b1}} << lo) &
             ({pba_pkg::WORD_BITS{1'b1}} >>
              (pba_pkg::WORD_IDX_W'(pba_pkg::WORD_BITS - 1) - hi));
      is_last   = (waddr_ff == last_ff[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W]);
      base_wide = {first_ff, pba_pkg::PAGE_SHIFT'(0)};

      case (state_ff)
         // sweep the map clear after reset
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_data  = '0;
            waddr_in = waddr_ff + 1'b1;
            if (waddr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end
         // argument checks and set-up of the walk
         ST_DECODE: begin
            run_in   = '0;
            sub_in   = '0;
            check_in = 1'b1;
            first_in = pidx_wide[pba_pkg::PIDX_W-1:0];
            last_in  = pidx_wide[pba_pkg::PIDX_W-1:0];
            waddr_in = pidx_wide[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W];
            case (req_ff.mode)
               pba_pkg::MODE_ALLOC_ONE: begin
                  len_in   = pba_pkg::RUN_W'(1);
                  waddr_in = '0;
                  state_in = ST_SREAD;
               end
               pba_pkg::MODE_ALLOC_RUN: begin
                  len_in   = req_ff.length[pba_pkg::RUN_W-1:0];
                  waddr_in = '0;
                  if (req_ff.length != 32'd0 &&
                      req_ff.length <= 32'(pba_pkg::MAP_PAGES)) begin
                     state_in = ST_SREAD;
                  end else begin
                     fin = 1'b1;
                  end
               end
               pba_pkg::MODE_FREE: begin
                  if (pidx_wide < 32'(pba_pkg::MAP_PAGES)) begin
                     state_in = ST_FREAD;
                  end else begin
                     fin = 1'b1;
                  end
               end
               pba_pkg::MODE_RESERVE_ONE: begin
                  if (pidx_wide < 32'(pba_pkg::MAP_PAGES)) begin
                     state_in = ST_RREAD;
                  end else begin
                     fin = 1'b1;
                  end
               end
               pba_pkg::MODE_RESERVE_RANGE: begin
                  last_in = end_pg[pba_pkg::PIDX_W-1:0];
                  if (req_ff.addr <= req_ff.end_addr &&
                      end_pg < 32'(pba_pkg::MAP_PAGES)) begin
                     state_in = ST_RREAD;
                  end else begin
                     fin = 1'b1;
                  end
               end
               pba_pkg::MODE_RESERVE_SIZE: begin
                  last_in = size_pg[pba_pkg::PIDX_W-1:0];
                  if (req_ff.length != 32'd0 && !last_size[32] &&
                      size_pg < 32'(pba_pkg::MAP_PAGES)) begin
                     state_in = ST_RREAD;
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         // first-fit search, one map word per read
         ST_SREAD: begin
            state_in = ST_SWORD;
         end
         ST_SWORD: begin
            word_in = rd_data;
            if (&rd_data) begin
               run_in = '0;
               if (waddr_ff == LAST_WORD) begin
                  fin = 1'b1;
               end else begin
                  waddr_in = waddr_ff + 1'b1;
                  state_in = ST_SREAD;
               end
            end else if (rd_data == '0) begin
               if (sum >= len_ff) begin
                  last_in  = {waddr_ff,
                              pba_pkg::WORD_IDX_W'(len_ff - run_ff - 1'b1)};
                  state_in = ST_SFOUND;
               end else begin
                  run_in = sum;
                  if (waddr_ff == LAST_WORD) begin
                     fin = 1'b1;
                  end else begin
                     waddr_in = waddr_ff + 1'b1;
                     state_in = ST_SREAD;
                  end
               end
            end else begin
               sub_in   = '0;
               state_in = ST_SBITS;
            end
         end
         // mixed word: one byte of marks per cycle
         ST_SBITS: begin
            if (step_out.found) begin
               last_in  = {waddr_ff, sub_ff, step_out.pos};
               state_in = ST_SFOUND;
            end else begin
               run_in = step_out.run;
               sub_in = sub_ff + 1'b1;
               if (sub_ff == LAST_SUB) begin
                  if (waddr_ff == LAST_WORD) begin
                     fin = 1'b1;
                  end else begin
                     waddr_in = waddr_ff + 1'b1;
                     state_in = ST_SREAD;
                  end
               end
            end
         end
         // run end found: derive its start and go mark it
         ST_SFOUND: begin
            first_in = pba_pkg::PIDX_W'(pba_pkg::RUN_W'(last_ff) - len_ff + 1'b1);
            waddr_in = first_in[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W];
            check_in = 1'b0;
            state_in = ST_RREAD;
         end
         // range walk: check pass, then mark pass (a found run is only marked)
         ST_RREAD: begin
            state_in = ST_RWORD;
         end
         ST_RWORD: begin
            if (check_ff) begin
               if ((rd_data & mask) != '0) begin
                  fin = 1'b1;
               end else if (is_last) begin
                  check_in = 1'b0;
                  waddr_in = first_ff[pba_pkg::PIDX_W-1:pba_pkg::WORD_IDX_W];
                  state_in = ST_RREAD;
               end else begin
                  waddr_in = waddr_ff + 1'b1;
                  state_in = ST_RREAD;
               end
            end else begin
               wr_en   = 1'b1;
               wr_data = rd_data | mask;
               if (is_last) begin
                  count_in = count_ff + pba_pkg::CNT_W'({1'b0, last_ff} - {1'b0, first_ff})
                             + 1'b1;
                  fin      = 1'b1;
                  fin_ok   = 1'b1;
               end else begin
                  waddr_in = waddr_ff + 1'b1;
                  state_in = ST_RREAD;
               end
            end
         end
         // free: clear one mark
         ST_FREAD: begin
            state_in = ST_FWORD;
         end
         ST_FWORD: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~({{(pba_pkg::WORD_BITS-1){1'b0}}, 1'b1} <<
                                  first_ff[pba_pkg::WORD_IDX_W-1:0]);
            if (rd_data[first_ff[pba_pkg::WORD_IDX_W-1:0]]) begin
               count_in = count_ff - 1'b1;
            end
            fin    = 1'b1;
            fin_ok = 1'b1;
         end
         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_ok_ff ? pba_pkg::STATUS_OK : pba_pkg::STATUS_FAIL;
               rsp_in.base_addr   = res_base_ff;
               rsp_in.used_pages  = count_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         res_ok_in = fin_ok;
         res_base_in = (fin_ok && (req_ff.mode == pba_pkg::MODE_ALLOC_ONE ||
                                   req_ff.mode == pba_pkg::MODE_ALLOC_RUN)) ?
                       32'(base_wide) : 32'd0;
         state_in  = ST_DONE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         waddr_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waddr_ff     <= waddr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      word_ff     <= word_in;
      sub_ff      <= sub_in;
      run_ff      <= run_in;
      len_ff      <= len_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      check_ff    <= check_in;
      res_ok_ff   <= res_ok_in;
      res_base_ff <= res_base_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // used count never passes the map size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pba_pkg::CNT_W'(pba_pkg::MAP_PAGES))
      else $error("used page count beyond map size");

   // no result can appear while the map is being cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // a running search has not yet reached the wanted length
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SBITS |-> run_ff < len_ff)
      else $error("search run reached length without stopping");

   // range walk writes only in its mark pass
   assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff == ST_RWORD |-> !check_ff)
      else $error("map written during check pass");

endmodule
